// ----- hdl/bilinear_corner_gradient_pixel_defines.svh -----
// assertion macros for the bilinear corner gradient pixel block
`ifndef BILINEAR_CORNER_GRADIENT_PIXEL_DEFINES_SVH
`define BILINEAR_CORNER_GRADIENT_PIXEL_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on clk, off while rst_n is low
`define BCG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcg assertion failed");
// next-cycle implication, checked on clk, off while rst_n is low
`define BCG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcg assertion failed");
`else
`define BCG_ASSERT_IMP(lbl, ante, cons)
`define BCG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/bcg_pkg.sv -----
// shared types, constants and helpers for the bilinear corner gradient pixel block
package bcg_pkg;

  localparam int COORD_W   = 12;
  localparam int DIM_W     = 13;
  localparam int COLOR_W   = 24;
  localparam int CHAN_W    = 8;
  localparam int QUO_W     = 8;
  localparam int DIV_STEPS = QUO_W;
  localparam int REM_W     = COORD_W + CHAN_W;
  localparam int PROD_W    = 2 * CHAN_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int CORNERS   = 4;
  localparam int CHANNELS  = 3;
  localparam int CFG_ADDR_W = 3;

  localparam logic [DIM_W-1:0]   MAX_DIM        = 13'd4096;
  localparam logic [DIM_W-1:0]   RST_WIDTH      = 13'd256;
  localparam logic [DIM_W-1:0]   RST_HEIGHT     = 13'd256;
  localparam logic [CHAN_W-1:0]  WEIGHT_FULL    = 8'hff;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH        = 3'd0,
    REG_FRAME_HEIGHT       = 3'd1,
    REG_TOP_LEFT_COLOR     = 3'd2,
    REG_TOP_RIGHT_COLOR    = 3'd3,
    REG_BOTTOM_LEFT_COLOR  = 3'd4,
    REG_BOTTOM_RIGHT_COLOR = 3'd5
  } cfg_reg_t;

  // corner order: top-left, top-right, bottom-left, bottom-right
  typedef logic [CORNERS-1:0][COLOR_W-1:0] color_set_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t xl;
    div_lane_t yl;
    logic      oor;
  } div_item_t;

  typedef struct packed {
    logic [CORNERS-1:0][CHAN_W-1:0] fac;
    logic                           oor;
  } fac_item_t;

  typedef struct packed {
    logic [CHANNELS-1:0][CORNERS-1:0][PROD_W-1:0] prod;
    logic                                         oor;
  } prod_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              oor;
  } pix_item_t;

  // one restoring division step, quotient bits shift in from the right
  function automatic div_lane_t div_step(div_lane_t a, logic [REM_W-1:0] dsh);
    div_lane_t b;
    b = a;
    if (a.rem >= dsh) begin
      b.rem = a.rem - dsh;
      b.quo = {a.quo[QUO_W-2:0], 1'b1};
    end else begin
      b.quo = {a.quo[QUO_W-2:0], 1'b0};
    end
    return b;
  endfunction

endpackage

// ----- hdl/bcg_div_pipe.sv -----
// pipelined restoring divider, one quotient bit per stage for both axes
module bcg_div_pipe import bcg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  div_item_t        in_data,
  input  logic [DIM_W-1:0] width_div,
  input  logic [DIM_W-1:0] height_div,
  output logic             out_valid,
  input  logic             out_ready,
  output div_item_t        out_data
);

  logic [DIV_STEPS-1:0] v_r;
  div_item_t            d_r   [DIV_STEPS];
  div_item_t            d_nxt [DIV_STEPS];
  div_item_t            src   [DIV_STEPS];
  logic [DIV_STEPS-1:0] src_v;
  logic [DIV_STEPS:0]   rdy;

  assign rdy[DIV_STEPS] = out_ready;
  assign in_ready       = rdy[0];
  assign out_valid      = v_r[DIV_STEPS-1];
  assign out_data       = d_r[DIV_STEPS-1];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int SH = DIV_STEPS - 1 - k;
    logic [REM_W-1:0] wsh;
    logic [REM_W-1:0] hsh;

    if (k == 0) begin : g_first
      assign src[k]   = in_data;
      assign src_v[k] = in_valid;
    end else begin : g_next
      assign src[k]   = d_r[k-1];
      assign src_v[k] = v_r[k-1];
    end

    // divisor aligned to the quotient bit this stage resolves
    assign wsh = {{(REM_W-DIM_W){1'b0}}, width_div} << SH;
    assign hsh = {{(REM_W-DIM_W){1'b0}}, height_div} << SH;

    assign rdy[k]   = !v_r[k] || rdy[k+1];
    assign d_nxt[k] = '{xl: div_step(src[k].xl, wsh),
                        yl: div_step(src[k].yl, hsh),
                        oor: src[k].oor};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v[k]) begin
        d_r[k] <= d_nxt[k];
      end
    end
  end

endmodule

// ----- hdl/bcg_blend.sv -----
// corner factors, channel products and weighted sums over three stages
module bcg_blend import bcg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  div_item_t  in_data,
  input  color_set_t corner_color,
  output logic       out_valid,
  input  logic       out_ready,
  output pix_item_t  out_data
);

  logic       fac_v_r, prd_v_r, pix_v_r;
  fac_item_t  fac_r, fac_nxt;
  prod_item_t prd_r, prd_nxt;
  pix_item_t  pix_r, pix_nxt;
  logic       fac_rdy, prd_rdy, pix_rdy;

  logic [CHAN_W-1:0] wr, wl, wb, wt;
  logic [PROD_W-1:0] p_tl, p_tr, p_bl, p_br;

  assign pix_rdy   = !pix_v_r || out_ready;
  assign prd_rdy   = !prd_v_r || pix_rdy;
  assign fac_rdy   = !fac_v_r || prd_rdy;
  assign in_ready  = fac_rdy;
  assign out_valid = pix_v_r;
  assign out_data  = pix_r;

  // corner factors
  assign wr = in_data.xl.quo;
  assign wb = in_data.yl.quo;
  assign wl = WEIGHT_FULL - wr;
  assign wt = WEIGHT_FULL - wb;
  assign p_tl = PROD_W'(wl) * PROD_W'(wt);
  assign p_tr = PROD_W'(wr) * PROD_W'(wt);
  assign p_bl = PROD_W'(wl) * PROD_W'(wb);
  assign p_br = PROD_W'(wr) * PROD_W'(wb);

  always_comb begin
    fac_nxt.fac[0] = p_tl[PROD_W-1:CHAN_W];
    fac_nxt.fac[1] = p_tr[PROD_W-1:CHAN_W];
    fac_nxt.fac[2] = p_bl[PROD_W-1:CHAN_W];
    fac_nxt.fac[3] = p_br[PROD_W-1:CHAN_W];
    fac_nxt.oor    = in_data.oor;
  end

  // channel 0 is red, the top byte of each color
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < CORNERS; k++) begin
        prd_nxt.prod[c][k] = PROD_W'(fac_r.fac[k]) *
          PROD_W'(corner_color[k][COLOR_W-1-CHAN_W*c -: CHAN_W]);
      end
    end
    prd_nxt.oor = fac_r.oor;
  end

  always_comb begin
    logic [CHANNELS-1:0][SUM_W-1:0] sum;
    for (int c = 0; c < CHANNELS; c++) begin
      sum[c] = SUM_W'(prd_r.prod[c][0]) + SUM_W'(prd_r.prod[c][1])
             + SUM_W'(prd_r.prod[c][2]) + SUM_W'(prd_r.prod[c][3]);
    end
    pix_nxt.oor   = prd_r.oor;
    pix_nxt.red   = prd_r.oor ? '0 : sum[0][PROD_W-1:CHAN_W];
    pix_nxt.green = prd_r.oor ? '0 : sum[1][PROD_W-1:CHAN_W];
    pix_nxt.blue  = prd_r.oor ? '0 : sum[2][PROD_W-1:CHAN_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fac_v_r <= 1'b0;
      prd_v_r <= 1'b0;
      pix_v_r <= 1'b0;
    end else begin
      if (fac_rdy) fac_v_r <= in_valid;
      if (prd_rdy) prd_v_r <= fac_v_r;
      if (pix_rdy) pix_v_r <= prd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fac_rdy && in_valid) fac_r <= fac_nxt;
    if (prd_rdy && fac_v_r)  prd_r <= prd_nxt;
    if (pix_rdy && prd_v_r)  pix_r <= pix_nxt;
  end

endmodule

// ----- hdl/bilinear_corner_gradient_pixel.sv -----
// bilinear four-corner gradient: pixel coordinate in, blended rgb out
// pipeline: 1 entry, 8 divide and 3 blend stages from input transfer to output valid
// throughput: one pixel per cycle while out_tready stays high; every stage holds its item until the next one frees
// reset (rst_n low, synchronous) empties the pipeline and loads frame 256 x 256, colors black
// config writes take effect at once and must only happen while no pixel is in flight
`include "bilinear_corner_gradient_pixel_defines.svh"
module bilinear_corner_gradient_pixel import bcg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COLOR_W-1:0]    cfg_wdata,
  // coordinate stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // pixel_x [11:0], pixel_y [23:12]
  // pixel stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // red [7:0], green [15:8], blue [23:16]
  output logic                  out_tuser   // out_of_range
);

  // configuration registers
  logic [DIM_W-1:0]   frame_width_r, frame_height_r;
  color_set_t         corner_color_r;
  logic [DIM_W-1:0]   width_sat, height_sat;

  // entry stage
  logic               v0_r;
  div_item_t          s0_r, s0_nxt;
  logic [COORD_W-1:0] pixel_x, pixel_y;

  // divider to blend
  logic               div_in_ready;
  logic               div_out_valid;
  div_item_t          div_out_data;
  logic               blend_in_ready;
  pix_item_t          pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_WIDTH;
      frame_height_r <= RST_HEIGHT;
      corner_color_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:        frame_width_r     <= cfg_wdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:       frame_height_r    <= cfg_wdata[DIM_W-1:0];
        REG_TOP_LEFT_COLOR:     corner_color_r[0] <= cfg_wdata;
        REG_TOP_RIGHT_COLOR:    corner_color_r[1] <= cfg_wdata;
        REG_BOTTOM_LEFT_COLOR:  corner_color_r[2] <= cfg_wdata;
        REG_BOTTOM_RIGHT_COLOR: corner_color_r[3] <= cfg_wdata;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // frame sizes above the maximum clamp to it
  assign width_sat  = (frame_width_r  > MAX_DIM) ? MAX_DIM : frame_width_r;
  assign height_sat = (frame_height_r > MAX_DIM) ? MAX_DIM : frame_height_r;

  assign pixel_x = in_tdata[COORD_W-1:0];
  assign pixel_y = in_tdata[2*COORD_W-1:COORD_W];

  // dividends 255*x and 255*y; out-of-frame check also covers a zero size
  always_comb begin
    s0_nxt.xl.rem = {pixel_x, CHAN_W'(0)} - {CHAN_W'(0), pixel_x};
    s0_nxt.yl.rem = {pixel_y, CHAN_W'(0)} - {CHAN_W'(0), pixel_y};
    s0_nxt.xl.quo = '0;
    s0_nxt.yl.quo = '0;
    s0_nxt.oor    = (width_sat == '0) || (height_sat == '0)
                 || ({1'b0, pixel_x} >= width_sat)
                 || ({1'b0, pixel_y} >= height_sat);
  end

  assign in_tready = !v0_r || div_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_tready) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_r <= s0_nxt;
    end
  end

  // horizontal and vertical weights, one quotient bit per stage
  bcg_div_pipe u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v0_r),
    .in_ready   (div_in_ready),
    .in_data    (s0_r),
    .width_div  (width_sat),
    .height_div (height_sat),
    .out_valid  (div_out_valid),
    .out_ready  (blend_in_ready),
    .out_data   (div_out_data)
  );

  // corner factors, products, sums; last stage is the output register
  bcg_blend u_blend (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (div_out_valid),
    .in_ready     (blend_in_ready),
    .in_data      (div_out_data),
    .corner_color (corner_color_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_data     (pix)
  );

  assign out_tdata = {pix.blue, pix.green, pix.red};
  assign out_tuser = pix.oor;

  // out-of-frame pixels come out black
  `BCG_ASSERT_IMP(a_oor_black, out_tvalid && out_tuser, out_tdata == '0)
  // the blend never reaches full scale on any channel
  `BCG_ASSERT_IMP(a_chan_max, out_tvalid,
    (pix.red != 8'hff) && (pix.green != 8'hff) && (pix.blue != 8'hff))
  // a held entry item stays put while the divider is full
  `BCG_ASSERT_NXT(a_entry_hold, v0_r && !div_in_ready, v0_r && $stable(s0_r))

endmodule

// ----- sim/tb.sv -----
// self-checking testbench for the bilinear four-corner gradient pixel block
module tb;
  import bcg_pkg::*;

  // indexes past the register list, written to make sure the block ignores them
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer or register write
  localparam int LONG_HOLD      = 80;    // receiver hold-off, well past pipeline depth
  localparam int DRAIN_TAIL     = 20;    // quiet cycles at the end, above pipeline depth
  localparam int PHASES         = 10;
  localparam int PHASE_PIXELS   = 120;

  // predictor and store of expected pixel colors
  class pixel_color_checker;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [COLOR_W-1:0] corner [CORNERS];
    pix_item_t          expected_colors [$];
    int                 errors;

    function new();
      width   = RST_WIDTH;
      height  = RST_HEIGHT;
      foreach (corner[i]) corner[i] = '0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [COLOR_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH:        width     = val[DIM_W-1:0];
        REG_FRAME_HEIGHT:       height    = val[DIM_W-1:0];
        REG_TOP_LEFT_COLOR:     corner[0] = val;
        REG_TOP_RIGHT_COLOR:    corner[1] = val;
        REG_BOTTOM_LEFT_COLOR:  corner[2] = val;
        REG_BOTTOM_RIGHT_COLOR: corner[3] = val;
        default: ;
      endcase
    endfunction

    // blend the four corners for one coordinate
    function pix_item_t blend_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      pix_item_t   p;
      int unsigned xi, yi, w, h, wr, wl, wb, wt, s, sh;
      int unsigned fac [CORNERS];
      logic [CHAN_W-1:0] lvl [CHANNELS];
      p  = '0;
      xi = 32'(x);
      yi = 32'(y);
      w  = 32'((width  > MAX_DIM) ? MAX_DIM : width);
      h  = 32'((height > MAX_DIM) ? MAX_DIM : height);
      if (w == 0 || h == 0 || xi >= w || yi >= h) begin
        p.oor = 1'b1;
        return p;
      end
      wr = (255 * xi) / w;
      wl = 255 - wr;
      wb = (255 * yi) / h;
      wt = 255 - wb;
      fac[0] = (wl * wt) >> 8;
      fac[1] = (wr * wt) >> 8;
      fac[2] = (wl * wb) >> 8;
      fac[3] = (wr * wb) >> 8;
      // channel 0 is red in the upper byte of a corner color
      for (int c = 0; c < CHANNELS; c++) begin
        sh = 16 - 8 * c;
        s  = 0;
        for (int k = 0; k < CORNERS; k++) s += fac[k] * ((corner[k] >> sh) & 255);
        lvl[c] = CHAN_W'((s >> 8) & 255);
      end
      p.red   = lvl[0];
      p.green = lvl[1];
      p.blue  = lvl[2];
      return p;
    endfunction

    function void note_coord(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      expected_colors.push_back(blend_pixel(x, y));
    endfunction

    function void check_color(logic [23:0] data, logic flag);
      pix_item_t e;
      if (expected_colors.size() == 0) begin
        $error("pixel transfer with no coordinate outstanding: data %h flag %b", data, flag);
        errors++;
        return;
      end
      e = expected_colors.pop_front();
      if (data[7:0] !== e.red) begin
        $error("red mismatch: expected %0d, actual %0d", e.red, data[7:0]);
        errors++;
      end
      if (data[15:8] !== e.green) begin
        $error("green mismatch: expected %0d, actual %0d", e.green, data[15:8]);
        errors++;
      end
      if (data[23:16] !== e.blue) begin
        $error("blue mismatch: expected %0d, actual %0d", e.blue, data[23:16]);
        errors++;
      end
      if (flag !== e.oor) begin
        $error("out_of_range mismatch: expected %0b, actual %0b", e.oor, flag);
        errors++;
      end
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [COLOR_W-1:0]    cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata   = '0;  // pixel_x [11:0], pixel_y [23:12]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;        // red [7:0], green [15:8], blue [23:16]
  logic                  out_tuser;        // out_of_range

  pixel_color_checker colors = new();

  // knobs from the sender process for itself and the receiver, and the watchdog count
  bit tx_idle_en  = 1'b0;
  bit rx_idle_en  = 1'b1;
  int rx_hold_len = 0;
  int quiet_cycles = 0;

  bilinear_corner_gradient_pixel dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 unit clock period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: values read right at the edge are the ones the block saw
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) colors.note_coord(in_tdata[11:0], in_tdata[23:12]);
      if (out_tvalid && out_tready) colors.check_color(out_tdata, out_tuser);
    end
  end

  // watchdog: any transfer or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: ready by default, random stall bursts, and one long hold-off on request
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (rx_hold_len != 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // one register write; the enable stays up for back-to-back writes
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [COLOR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    colors.write_reg(idx, val);
    @(posedge clk);
  endtask

  // full register set; junk above the frame size bits and in the spare slots
  task automatic load_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic [COLOR_W-1:0] tl, input logic [COLOR_W-1:0] tr,
                            input logic [COLOR_W-1:0] bl, input logic [COLOR_W-1:0] br);
    logic [31:0] junk;
    junk = $urandom;
    cfg_write(REG_FRAME_WIDTH, {junk[10:0], w});
    cfg_write(REG_FRAME_HEIGHT, {junk[21:11], h});
    cfg_write(REG_TOP_LEFT_COLOR, tl);
    cfg_write(REG_TOP_RIGHT_COLOR, tr);
    cfg_write(REG_BOTTOM_LEFT_COLOR, bl);
    cfg_write(REG_BOTTOM_RIGHT_COLOR, br);
    cfg_write(REG_SPARE_LO, COLOR_W'($urandom));
    cfg_write(REG_SPARE_HI, COLOR_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // offer one coordinate and hold it until the transfer
  task automatic send_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic rest_input(input int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // sender pause until every expected pixel has come back
  task automatic drain_pixels();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (colors.pending() != 0);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 13'd1;
      1:       return MAX_DIM;
      2:       return DIM_W'($urandom_range(4097, 8191));   // saturates to the maximum
      3:       return 13'd0;                                // whole frame out of range
      4, 5:    return DIM_W'($urandom_range(1, 64));
      default: return DIM_W'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return 24'hffffff;
      default: return COLOR_W'($urandom_range(0, 24'hffffff));
    endcase
  endfunction

  // mostly inside the frame, some on the border, some anywhere
  function automatic logic [COORD_W-1:0] pick_coord(input logic [DIM_W-1:0] dim);
    int unsigned eff;
    eff = 32'((dim > MAX_DIM) ? MAX_DIM : dim);
    if (eff == 0) return COORD_W'($urandom_range(0, 4095));
    case ($urandom_range(0, 7))
      0, 1:    return COORD_W'($urandom_range(0, 4095));
      2:       return (eff > 4095) ? 12'd4095 : COORD_W'(eff - $urandom_range(0, 1));
      default: return COORD_W'($urandom_range(0, eff - 1));
    endcase
  endfunction

  initial begin
    logic [DIM_W-1:0] w, h;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset frame 256 x 256, all corners black
    send_coord(12'd0, 12'd0);
    send_coord(12'd255, 12'd255);
    send_coord(12'd256, 12'd0);
    send_coord(12'd0, 12'd256);
    send_coord(12'd4095, 12'd4095);
    drain_pixels();

    // largest frame, all corners white: brightest output
    load_frame(MAX_DIM, MAX_DIM, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
    send_coord(12'd0, 12'd0);
    send_coord(12'd4095, 12'd4095);
    send_coord(12'd4095, 12'd0);
    send_coord(12'd0, 12'd4095);
    send_coord(12'd2048, 12'd1000);
    drain_pixels();

    // frame size above the maximum saturates
    load_frame(13'd8191, 13'd5000, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'h808080);
    send_coord(12'd4095, 12'd4095);
    send_coord(12'd0, 12'd0);
    send_coord(12'd4095, 12'd2000);
    drain_pixels();

    // zero width, then zero height: everything out of range
    load_frame(13'd0, 13'd10, 24'hffffff, 24'h123456, 24'habcdef, 24'h7f7f7f);
    send_coord(12'd0, 12'd0);
    send_coord(12'd5, 12'd5);
    drain_pixels();
    load_frame(13'd10, 13'd0, 24'hffffff, 24'h123456, 24'habcdef, 24'h7f7f7f);
    send_coord(12'd0, 12'd0);
    drain_pixels();

    // single pixel frame
    load_frame(13'd1, 13'd1, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
    send_coord(12'd0, 12'd0);
    send_coord(12'd1, 12'd0);
    send_coord(12'd0, 12'd1);
    send_coord(12'd4095, 12'd4095);
    drain_pixels();

    // random frames; idling off every third phase and the last; tx idling off in phase 1
    for (int phase = 0; phase < PHASES; phase++) begin
      w = pick_dim();
      h = pick_dim();
      load_frame(w, h, pick_color(), pick_color(), pick_color(), pick_color());
      tx_idle_en = (phase != PHASES - 1) && (phase % 3 != 2) && (phase != 1);
      rx_idle_en = (phase != PHASES - 1) && (phase % 3 != 2);
      // long receiver hold while the sender streams: pipeline fills, input stalls
      if (phase == 1) rx_hold_len = LONG_HOLD;
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (tx_idle_en && $urandom_range(0, 7) == 0) rest_input($urandom_range(1, 16));
        send_coord(pick_coord(w), pick_coord(h));
      end
      drain_pixels();
    end

    // nothing more may come out
    repeat (DRAIN_TAIL) @(posedge clk);
    if (colors.errors == 0 && colors.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
